/* hdl/amiu_pkg.sv */
// Shared types, constants and the micro-operation table of the affine matrix inverse unit.
// Used by every module of the block; depends on nothing.
`default_nettype none
package amiu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int ELEM_N        = 12;
    localparam int COF_N         = 9;
    localparam int IDX_W         = 4;
    localparam int COF_W         = 64;
    localparam int MUL_AW        = 64;
    localparam int MUL_BW        = 32;
    localparam int DIGIT_W       = 4;
    localparam int PROD_W        = MUL_AW + MUL_BW;
    localparam int ACC_W         = 100;
    localparam int Q_W           = 32;
    localparam int STEP_W        = 5;

    localparam logic [STEP_W-1:0] STEP_DET_LAST  = 5'd20;
    localparam logic [STEP_W-1:0] STEP_TRN_FIRST = 5'd21;
    localparam logic [STEP_W-1:0] STEP_TRN_LAST  = 5'd29;
    localparam logic [IDX_W-1:0]  ELEM_LAST      = 4'd11;
    localparam logic [IDX_W-1:0]  COF_LAST       = 4'd8;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_OPA,
        ST_OPB,
        ST_MUL,
        ST_ACC,
        ST_END,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        SRC_MEM,
        SRC_COF,
        SRC_INV
    } t_asrc;

    typedef enum logic [1:0] {
        END_NONE,
        END_COF,
        END_DET,
        END_TRN
    } t_uend;

    typedef struct packed {
        t_asrc            a_src;
        logic [IDX_W-1:0] a_idx;
        logic [IDX_W-1:0] b_idx;
        logic             clr;
        logic             sub;
        t_uend            fin;
        logic [IDX_W-1:0] dst;
    } t_uop;

    typedef struct packed {
        logic              start;
        logic [MUL_AW-1:0] a_mag;
        logic [MUL_BW-1:0] b_mag;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } t_mul_rsp;

    function automatic t_uop uop_rom(input logic [STEP_W-1:0] idx);
        t_uop u;
        u = '{SRC_MEM, 4'd0, 4'd0, 1'b0, 1'b0, END_NONE, 4'd0};
        unique case (idx)
            5'd0:  u = '{SRC_MEM, 4'd5, 4'd10, 1'b1, 1'b0, END_NONE, 4'd0};
            5'd1:  u = '{SRC_MEM, 4'd9, 4'd6,  1'b0, 1'b1, END_COF,  4'd0};
            5'd2:  u = '{SRC_MEM, 4'd9, 4'd2,  1'b1, 1'b0, END_NONE, 4'd0};
            5'd3:  u = '{SRC_MEM, 4'd1, 4'd10, 1'b0, 1'b1, END_COF,  4'd1};
            5'd4:  u = '{SRC_MEM, 4'd1, 4'd6,  1'b1, 1'b0, END_NONE, 4'd0};
            5'd5:  u = '{SRC_MEM, 4'd5, 4'd2,  1'b0, 1'b1, END_COF,  4'd2};
            5'd6:  u = '{SRC_MEM, 4'd8, 4'd6,  1'b1, 1'b0, END_NONE, 4'd0};
            5'd7:  u = '{SRC_MEM, 4'd4, 4'd10, 1'b0, 1'b1, END_COF,  4'd3};
            5'd8:  u = '{SRC_MEM, 4'd0, 4'd10, 1'b1, 1'b0, END_NONE, 4'd0};
            5'd9:  u = '{SRC_MEM, 4'd8, 4'd2,  1'b0, 1'b1, END_COF,  4'd4};
            5'd10: u = '{SRC_MEM, 4'd4, 4'd2,  1'b1, 1'b0, END_NONE, 4'd0};
            5'd11: u = '{SRC_MEM, 4'd0, 4'd6,  1'b0, 1'b1, END_COF,  4'd5};
            5'd12: u = '{SRC_MEM, 4'd4, 4'd9,  1'b1, 1'b0, END_NONE, 4'd0};
            5'd13: u = '{SRC_MEM, 4'd8, 4'd5,  1'b0, 1'b1, END_COF,  4'd6};
            5'd14: u = '{SRC_MEM, 4'd8, 4'd1,  1'b1, 1'b0, END_NONE, 4'd0};
            5'd15: u = '{SRC_MEM, 4'd0, 4'd9,  1'b0, 1'b1, END_COF,  4'd7};
            5'd16: u = '{SRC_MEM, 4'd0, 4'd5,  1'b1, 1'b0, END_NONE, 4'd0};
            5'd17: u = '{SRC_MEM, 4'd4, 4'd1,  1'b0, 1'b1, END_COF,  4'd8};
            5'd18: u = '{SRC_COF, 4'd0, 4'd0,  1'b1, 1'b0, END_NONE, 4'd0};
            5'd19: u = '{SRC_COF, 4'd1, 4'd4,  1'b0, 1'b0, END_NONE, 4'd0};
            5'd20: u = '{SRC_COF, 4'd2, 4'd8,  1'b0, 1'b0, END_DET,  4'd0};
            5'd21: u = '{SRC_INV, 4'd0, 4'd3,  1'b1, 1'b0, END_NONE, 4'd0};
            5'd22: u = '{SRC_INV, 4'd1, 4'd7,  1'b0, 1'b0, END_NONE, 4'd0};
            5'd23: u = '{SRC_INV, 4'd2, 4'd11, 1'b0, 1'b0, END_TRN,  4'd3};
            5'd24: u = '{SRC_INV, 4'd4, 4'd3,  1'b1, 1'b0, END_NONE, 4'd0};
            5'd25: u = '{SRC_INV, 4'd5, 4'd7,  1'b0, 1'b0, END_NONE, 4'd0};
            5'd26: u = '{SRC_INV, 4'd6, 4'd11, 1'b0, 1'b0, END_TRN,  4'd7};
            5'd27: u = '{SRC_INV, 4'd8, 4'd3,  1'b1, 1'b0, END_NONE, 4'd0};
            5'd28: u = '{SRC_INV, 4'd9, 4'd7,  1'b0, 1'b0, END_NONE, 4'd0};
            5'd29: u = '{SRC_INV, 4'd10, 4'd11, 1'b0, 1'b0, END_TRN, 4'd11};
            default: u = '{SRC_MEM, 4'd0, 4'd0, 1'b0, 1'b0, END_NONE, 4'd0};
        endcase
        return u;
    endfunction

    function automatic logic [IDX_W-1:0] div_dst(input logic [IDX_W-1:0] k);
        logic [IDX_W-1:0] d;
        unique case (k)
            4'd0:    d = 4'd0;
            4'd1:    d = 4'd1;
            4'd2:    d = 4'd2;
            4'd3:    d = 4'd4;
            4'd4:    d = 4'd5;
            4'd5:    d = 4'd6;
            4'd6:    d = 4'd8;
            4'd7:    d = 4'd9;
            4'd8:    d = 4'd10;
            default: d = 4'd0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

/* hdl/amiu_mul.sv */
// Digit-serial unsigned multiplier, 64 by 32 bits, four multiplier bits per cycle.
// Depends on amiu_pkg.
`default_nettype none
module amiu_mul
    import amiu_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    localparam int STEPS = MUL_BW / DIGIT_W;
    localparam int CNT_W = $clog2(STEPS);

    logic [PROD_W-1:0] r_a_sh;
    logic [MUL_BW-1:0] r_b;
    logic [PROD_W-1:0] r_p;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              w_last;

    assign w_last = r_busy && (r_cnt == CNT_W'(STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a_sh <= PROD_W'(i_req.a_mag);
            r_b    <= i_req.b_mag;
            r_p    <= '0;
        end else if (r_busy) begin
            r_p    <= r_p + r_a_sh * PROD_W'(r_b[DIGIT_W-1:0]);
            r_a_sh <= r_a_sh << DIGIT_W;
            r_b    <= r_b >> DIGIT_W;
        end
    end

    assign o_rsp.done = w_last;
    assign o_rsp.prod = r_p;

endmodule
`default_nettype wire

/* hdl/amiu_div.sv */
// Restoring divider that yields one quotient bit per cycle, with an up-front overflow check.
// Depends on amiu_pkg.
`default_nettype none
module amiu_div
    import amiu_pkg::*;
#(
    parameter int NUM_W = COF_W + 2 * FRAC_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [ACC_W-1:0] i_den,
    output logic                  o_done,
    output logic                  o_ovf,
    output logic [Q_W-1:0]        o_quo
);

    localparam int RW    = ACC_W + 1;
    localparam int CNT_W = $clog2(Q_W);

    logic [RW-1:0]    r_rem;
    logic [Q_W-1:0]   r_low;
    logic [Q_W-1:0]   r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_ovf;
    logic [RW-1:0]    w_hi;
    logic [RW-1:0]    w_den;
    logic [RW-1:0]    w_trial;
    logic             w_fit;

    assign w_hi    = RW'(i_num[NUM_W-1:Q_W]);
    assign w_den   = RW'(i_den);
    assign w_trial = {r_rem[RW-2:0], r_low[Q_W-1]};
    assign w_fit   = (w_trial >= w_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                if (w_hi >= w_den) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ovf <= (w_hi >= w_den);
            r_rem <= w_hi;
            r_low <= i_num[Q_W-1:0];
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_fit ? (w_trial - w_den) : w_trial;
            r_low <= r_low << 1;
            r_quo <= {r_quo[Q_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_ovf  = r_ovf;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

/* hdl/affine_matrix_inverse_unit.sv */
// Affine 3x4 matrix inverse: element store, micro-op sequencer, result emitter.
// Depends on amiu_pkg, amiu_mul and amiu_div.
// The sequencer runs 30 serial products through the four-bit digit-serial multiplier and
// 9 divisions on the shared bit-per-cycle divider; the divisions are skipped when singular.
// Reset is synchronous, active low.
`default_nettype none
module affine_matrix_inverse_unit
    import amiu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic signed [DATA_W-1:0] i_element_value,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [IDX_W-1:0]              o_element_index,
    output logic signed [DATA_W-1:0]      o_result_value,
    output logic                          o_singular,
    output logic                          o_last
);

    localparam int NUM_W = COF_W + 2 * FRAC_BITS;

    t_state r_state, n_state;

    logic [DATA_W-1:0] r_mem [ELEM_N];
    logic [COF_W-1:0]  r_cof [COF_N];
    logic [DATA_W-1:0] r_inv [ELEM_N];

    logic [IDX_W-1:0]  r_load_cnt;
    logic [STEP_W-1:0] r_step;
    logic [IDX_W-1:0]  r_div_k;
    logic [IDX_W-1:0]  r_emit_idx;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  r_det;
    logic              r_sing;
    logic [MUL_AW-1:0] r_opa_mag;
    logic              r_opa_neg;
    logic              r_neg;

    logic              r_o_valid;
    logic [IDX_W-1:0]  r_o_index;
    logic [DATA_W-1:0] r_o_value;
    logic              r_o_sing;
    logic              r_o_last;

    t_uop              w_uop;
    logic              w_in_acc;
    logic              w_out_free;
    logic [IDX_W-1:0]  w_mem_addr;
    logic [IDX_W-1:0]  w_cof_addr;
    logic [IDX_W-1:0]  w_inv_addr;
    logic [DATA_W-1:0] w_mem_rd;
    logic [COF_W-1:0]  w_cof_rd;
    logic [DATA_W-1:0] w_inv_rd;
    logic [MUL_AW-1:0] w_opa;
    logic [ACC_W-1:0]  w_term;
    logic [COF_W-1:0]  w_cof_mag;
    logic [ACC_W-1:0]  w_det_mag;
    logic [NUM_W-1:0]  w_div_num;
    logic [DATA_W-1:0] w_quo_sat;
    logic [DATA_W-1:0] w_trn_sat;
    logic [ACC_W-1:0]  w_trn_neg;
    logic [ACC_W-1:0]  w_trn_sh;
    logic              w_div_start;
    logic              w_div_done;
    logic              w_div_ovf;
    logic [Q_W-1:0]    w_div_quo;
    logic              w_div_neg;
    t_mul_req          w_mul_req;
    t_mul_rsp          w_mul_rsp;

    assign w_uop      = uop_rom(r_step);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_o_valid || !i_stall;

    assign w_mem_addr = (r_state == ST_OPA) ? w_uop.a_idx : w_uop.b_idx;
    assign w_cof_addr = (r_state == ST_OPA) ? w_uop.a_idx : r_div_k;
    assign w_inv_addr = (r_state == ST_EMIT) ? r_emit_idx : w_uop.a_idx;
    assign w_mem_rd   = r_mem[w_mem_addr];
    assign w_cof_rd   = r_cof[w_cof_addr];
    assign w_inv_rd   = r_inv[w_inv_addr];

    always_comb begin
        case (w_uop.a_src)
            SRC_COF: w_opa = w_cof_rd;
            SRC_INV: w_opa = {{(MUL_AW-DATA_W){w_inv_rd[DATA_W-1]}}, w_inv_rd};
            default: w_opa = {{(MUL_AW-DATA_W){w_mem_rd[DATA_W-1]}}, w_mem_rd};
        endcase
    end

    assign w_mul_req.start = (r_state == ST_OPB);
    assign w_mul_req.a_mag = r_opa_mag;
    assign w_mul_req.b_mag = w_mem_rd[DATA_W-1] ? (~w_mem_rd + 1'b1) : w_mem_rd;

    amiu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    assign w_term    = ACC_W'(w_mul_rsp.prod);
    assign w_cof_mag = w_cof_rd[COF_W-1] ? (~w_cof_rd + 1'b1) : w_cof_rd;
    assign w_det_mag = r_det[ACC_W-1] ? (~r_det + 1'b1) : r_det;
    assign w_div_num = NUM_W'(w_cof_mag) << (2 * FRAC_BITS);
    assign w_div_neg = w_cof_rd[COF_W-1] ^ r_det[ACC_W-1];

    amiu_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_det_mag),
        .o_done  (w_div_done),
        .o_ovf   (w_div_ovf),
        .o_quo   (w_div_quo)
    );

    always_comb begin
        if (!w_div_neg) begin
            w_quo_sat = (w_div_ovf || w_div_quo[Q_W-1]) ? SAT_MAX : w_div_quo;
        end else if (w_div_ovf || (w_div_quo[Q_W-1] && (w_div_quo[Q_W-2:0] != '0))) begin
            w_quo_sat = SAT_MIN;
        end else begin
            w_quo_sat = ~w_div_quo + 1'b1;
        end
    end

    assign w_trn_neg = ~r_acc + 1'b1;
    assign w_trn_sh  = ACC_W'($signed(w_trn_neg) >>> FRAC_BITS);

    always_comb begin
        if ((w_trn_sh[ACC_W-1:DATA_W-1] == '0) || (w_trn_sh[ACC_W-1:DATA_W-1] == '1)) begin
            w_trn_sat = w_trn_sh[DATA_W-1:0];
        end else begin
            w_trn_sat = w_trn_sh[ACC_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc && (r_load_cnt == ELEM_LAST)) begin
                    n_state = ST_OPA;
                end
            end
            ST_OPA: n_state = ST_OPB;
            ST_OPB: n_state = ST_MUL;
            ST_MUL: begin
                if (w_mul_rsp.done) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: n_state = (w_uop.fin == END_NONE) ? ST_OPA : ST_END;
            ST_END: begin
                if (r_step == STEP_DET_LAST) begin
                    n_state = ST_DIV_GO;
                end else if (r_step == STEP_TRN_LAST) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_OPA;
                end
            end
            ST_DIV_GO: begin
                if (!r_sing) begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIV_WAIT;
                end else if (r_div_k == COF_LAST) begin
                    n_state = ST_OPA;
                end
            end
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_div_k == COF_LAST) ? ST_OPA : ST_DIV_GO;
                end
            end
            ST_EMIT: begin
                if (w_out_free && (r_emit_idx == ELEM_LAST)) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
        end else if (w_in_acc) begin
            r_load_cnt <= (r_load_cnt == ELEM_LAST) ? '0 : r_load_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mem[r_load_cnt] <= i_element_value;
        end
        case (r_state)
            ST_LOAD: begin
                r_step     <= '0;
                r_div_k    <= '0;
                r_emit_idx <= '0;
            end
            ST_OPA: begin
                r_opa_mag <= w_opa[MUL_AW-1] ? (~w_opa + 1'b1) : w_opa;
                r_opa_neg <= w_opa[MUL_AW-1];
            end
            ST_OPB: begin
                r_neg <= r_opa_neg ^ w_mem_rd[DATA_W-1] ^ w_uop.sub;
            end
            ST_ACC: begin
                r_acc <= (w_uop.clr ? '0 : r_acc) + (r_neg ? (~w_term + 1'b1) : w_term);
                if (w_uop.fin == END_NONE) begin
                    r_step <= r_step + 1'b1;
                end
            end
            ST_END: begin
                case (w_uop.fin)
                    END_COF: r_cof[w_uop.dst] <= r_acc[COF_W-1:0];
                    END_DET: begin
                        r_det  <= r_acc;
                        r_sing <= (r_acc == '0);
                    end
                    END_TRN: r_inv[w_uop.dst] <= w_trn_sat;
                    default: ;
                endcase
                r_step <= r_step + 1'b1;
            end
            ST_DIV_GO: begin
                if (r_sing) begin
                    r_inv[div_dst(r_div_k)] <= '0;
                    r_div_k <= r_div_k + 1'b1;
                end
            end
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    r_inv[div_dst(r_div_k)] <= w_quo_sat;
                    r_div_k <= r_div_k + 1'b1;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    r_emit_idx <= r_emit_idx + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((r_state == ST_EMIT) && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && w_out_free) begin
            r_o_index <= r_emit_idx;
            r_o_value <= w_inv_rd;
            r_o_sing  <= r_sing;
            r_o_last  <= (r_emit_idx == ELEM_LAST);
        end
    end

    assign o_stall         = (r_state != ST_LOAD);
    assign o_valid         = r_o_valid;
    assign o_element_index = r_o_index;
    assign o_result_value  = r_o_value;
    assign o_singular      = r_o_sing;
    assign o_last          = r_o_last;

endmodule
`default_nettype wire

/* hdl/amiu_checker.sv */
// Port-level assertions for the affine matrix inverse unit, bound to its top level.
// Depends on amiu_pkg.
`default_nettype none
module amiu_checker
    import amiu_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_valid,
    input wire logic                     o_stall,
    input wire logic signed [DATA_W-1:0] i_element_value,
    input wire logic                     o_valid,
    input wire logic                     i_stall,
    input wire logic [IDX_W-1:0]         o_element_index,
    input wire logic signed [DATA_W-1:0] o_result_value,
    input wire logic                     o_singular,
    input wire logic                     o_last
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_element_value))
        else $error("A stalled input item changed.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_value)
            && $stable(o_element_index))
        else $error("A stalled result item changed.");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_result_value == '0)
        else $error("A singular result item is not zero.");

    a_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_stall)
        else $error("Input taken while results are still pending.");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=>
            o_valid && (o_element_index == $past(o_element_index) + 4'd1))
        else $error("Result items are out of order.");

endmodule

bind affine_matrix_inverse_unit amiu_checker u_amiu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_element_value (i_element_value),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_element_index (o_element_index),
    .o_result_value  (o_result_value),
    .o_singular      (o_singular),
    .o_last          (o_last)
);
`default_nettype wire

/* dv/tb_affine_matrix_inverse_unit.sv */
// Testbench for affine_matrix_inverse_unit: sends 3x4 Q16.16 matrices and checks each
// inverse element against a wide-integer predictor written in SystemVerilog.
// Depends on amiu_pkg and the unit under test.
`timescale 1ns / 1ps
module tb_affine_matrix_inverse_unit;
    import amiu_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
        logic                     singular;
        logic                     last;
    } t_inverse_elem;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic signed [DATA_W-1:0] i_element_value = '0;
    logic                     i_stall = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic [IDX_W-1:0]         o_element_index;
    logic signed [DATA_W-1:0] o_result_value;
    logic                     o_singular;
    logic                     o_last;

    t_inverse_elem            inverse_queue[$];
    logic signed [DATA_W-1:0] loaded_elems[ELEM_N];
    int                       load_pos = 0;
    int                       errors = 0;
    int                       cycle_count = 0;
    bit                       quiet = 1'b0;
    bit                       hold_req = 1'b0;
    bit                       hold_done = 1'b0;
    int                       hold_cnt = 0;

    affine_matrix_inverse_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_element_value (i_element_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_element_index (o_element_index),
        .o_result_value  (o_result_value),
        .o_singular      (o_singular),
        .o_last          (o_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic signed [127:0] wide(input longint x);
        logic signed [127:0] w;
        w = x;
        return w;
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return SAT_MAX;
        if (v < -128'sd2147483648) return SAT_MIN;
        return v[DATA_W-1:0];
    endfunction

    function automatic longint cofactor_quotient(input longint cof,
                                                 input logic signed [127:0] det);
        logic [63:0]  cmag;
        logic [127:0] num;
        logic [127:0] dmag;
        logic [127:0] q;
        if (cof == 0) return 0;
        cmag = (cof < 0) ? 64'(-cof) : 64'(cof);
        num = {64'd0, cmag} << (2 * FRAC_BITS_DEF);
        dmag = (det < 0) ? -det : det;
        q = num / dmag;
        if ((cof < 0) != (det < 0)) q = -q;
        return longint'(clamp32($signed(q)));
    endfunction

    task automatic predict_inverse();
        longint              e[ELEM_N];
        longint              cof[COF_N];
        longint              inv[ELEM_N];
        logic signed [127:0] det;
        logic signed [127:0] s;
        bit                  sing;
        t_inverse_elem       r;
        for (int i = 0; i < ELEM_N; i++) e[i] = longint'(loaded_elems[i]);
        det = wide(e[0] * e[5]) * wide(e[10]) + wide(e[4] * e[9]) * wide(e[2])
            + wide(e[8] * e[1]) * wide(e[6]) - wide(e[8] * e[5]) * wide(e[2])
            - wide(e[4] * e[1]) * wide(e[10]) - wide(e[0] * e[9]) * wide(e[6]);
        sing = (det == 0);
        cof[0] = e[5] * e[10] - e[9] * e[6];
        cof[1] = e[9] * e[2] - e[1] * e[10];
        cof[2] = e[1] * e[6] - e[5] * e[2];
        cof[3] = e[8] * e[6] - e[4] * e[10];
        cof[4] = e[0] * e[10] - e[8] * e[2];
        cof[5] = e[4] * e[2] - e[0] * e[6];
        cof[6] = e[4] * e[9] - e[8] * e[5];
        cof[7] = e[8] * e[1] - e[0] * e[9];
        cof[8] = e[0] * e[5] - e[4] * e[1];
        for (int i = 0; i < 3; i++) begin
            s = 0;
            for (int j = 0; j < 3; j++) begin
                inv[i*4+j] = sing ? 0 : cofactor_quotient(cof[i*3+j], det);
                s = s + wide(inv[i*4+j]) * wide(e[j*4+3]);
            end
            s = -s;
            inv[i*4+3] = sing ? 0 : longint'(clamp32(s >>> FRAC_BITS_DEF));
        end
        for (int i = 0; i < ELEM_N; i++) begin
            r.index = IDX_W'(i);
            r.value = inv[i][DATA_W-1:0];
            r.singular = sing;
            r.last = (IDX_W'(i) == ELEM_LAST);
            inverse_queue.push_back(r);
        end
    endtask

    task automatic send_element(input logic signed [DATA_W-1:0] v);
        if (!quiet) begin
            while ($urandom_range(99) < 21) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_element_value <= v;
        do @(posedge i_clk); while (o_stall);
        loaded_elems[load_pos] = v;
        load_pos++;
        if (load_pos == ELEM_N) begin
            load_pos = 0;
            predict_inverse();
        end
    endtask

    task automatic send_matrix(input logic signed [DATA_W-1:0] m[ELEM_N]);
        for (int i = 0; i < ELEM_N; i++) send_element(m[i]);
    endtask

    function automatic logic signed [DATA_W-1:0] near_unit();
        return DATA_W'($signed($urandom_range(32'h80000)) - 32'sh40000);
    endfunction

    task automatic send_random_matrix();
        logic signed [DATA_W-1:0] m[ELEM_N];
        int kind;
        kind = $urandom_range(9);
        for (int i = 0; i < ELEM_N; i++) begin
            if (kind < 4) m[i] = near_unit();
            else if (kind < 7) m[i] = $urandom;
            else if (kind < 8) m[i] = DATA_W'($signed($urandom_range(16)) - 8);
            else m[i] = ($urandom_range(1)) ? near_unit() : $urandom;
        end
        if (kind >= 8) begin
            for (int c = 0; c < 3; c++) m[8+c] = m[$urandom_range(1)*4+c];
        end
        send_matrix(m);
    endtask

    task automatic test_tiny_determinant();
        logic signed [DATA_W-1:0] m[ELEM_N];
        m = '{32'sd1, 32'sd0, 32'sd0, SAT_MAX,
              32'sd0, 32'sd1, 32'sd0, SAT_MIN,
              32'sd0, 32'sd0, -32'sd1, 32'sd0};
        send_matrix(m);
    endtask

    task automatic test_singular();
        logic signed [DATA_W-1:0] m[ELEM_N];
        for (int i = 0; i < ELEM_N; i++) m[i] = SAT_MIN;
        m[3] = SAT_MAX;
        send_matrix(m);
    endtask

    task automatic test_backpressure();
        hold_req <= 1'b1;
        repeat (3) send_random_matrix();
    endtask

    task automatic test_random();
        for (int n = 0; n < 18; n++) begin
            quiet = (n >= 6 && n < 9);
            send_random_matrix();
        end
        quiet = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= 3000;
            i_stall <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !quiet && ($urandom_range(99) < 21);
        end
    end

    always @(posedge i_clk) begin
        t_inverse_elem x;
        if (i_rst_n && o_valid && !i_stall) begin
            if (inverse_queue.size() == 0) begin
                $error("unexpected result index %0d value %0h", o_element_index,
                       o_result_value);
                errors++;
            end else begin
                x = inverse_queue.pop_front();
                if (o_element_index !== x.index) begin
                    $error("element_index expected %0d actual %0d", x.index,
                           o_element_index);
                    errors++;
                end
                if (o_result_value !== x.value) begin
                    $error("result_value expected %0h actual %0h", x.value, o_result_value);
                    errors++;
                end
                if (o_singular !== x.singular) begin
                    $error("singular expected %0b actual %0b", x.singular, o_singular);
                    errors++;
                end
                if (o_last !== x.last) begin
                    $error("last expected %0b actual %0b", x.last, o_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_tiny_determinant();
        test_singular();
        test_random();
        test_backpressure();
        i_valid <= 1'b0;
        while (inverse_queue.size() != 0) @(posedge i_clk);
        repeat (800) @(posedge i_clk);
        if (errors == 0 && inverse_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/amiu_pkg.sv
hdl/amiu_mul.sv
hdl/amiu_div.sv
hdl/affine_matrix_inverse_unit.sv
hdl/amiu_checker.sv
dv/tb_affine_matrix_inverse_unit.sv
